/* sv/sdlp_pkg.sv */
// Shared types and constants for the SSE data line parser.
package sdlp_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef enum logic [7:0] {
        PH_START  = 8'b0000_0001,
        PH_D      = 8'b0000_0010,
        PH_DA     = 8'b0000_0100,
        PH_DAT    = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_VSTART = 8'b0010_0000,
        PH_VALUE  = 8'b0100_0000,
        PH_IGNORE = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   cr_held;
        logic   event_nonempty;
    } t_parse_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

/* sv/sdlp_if.sv */
// Valid/ready channel interfaces for the parser's input and result streams.
interface sdlp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface sdlp_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_kind, output out_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input last_of_run,
                    output ready);
endinterface

/* sv/sdlp_core.sv */
// Next-state and result decode for one stream byte or flush.
module sdlp_core (
    input  logic                  i_mode,
    input  logic [7:0]            i_byte,
    input  sdlp_pkg::t_parse_state i_state,
    output sdlp_pkg::t_parse_state o_state,
    output sdlp_pkg::t_step       o_step
);

    sdlp_pkg::t_result w_marker;
    sdlp_pkg::t_result w_nl;
    sdlp_pkg::t_result w_cr;
    sdlp_pkg::t_result w_b;
    logic [7:0]        w_expect;

    assign w_marker = '{kind: sdlp_pkg::KIND_MARKER, data: 8'h00, last: 1'b1};
    assign w_nl     = '{kind: sdlp_pkg::KIND_BYTE, data: sdlp_pkg::CH_LF, last: 1'b1};
    assign w_cr     = '{kind: sdlp_pkg::KIND_BYTE, data: sdlp_pkg::CH_CR, last: 1'b0};
    assign w_b      = '{kind: sdlp_pkg::KIND_BYTE, data: i_byte, last: 1'b1};

    // next prefix character expected in each partial-match phase
    always_comb begin
        unique case (i_state.phase)
            sdlp_pkg::PH_D:    w_expect = sdlp_pkg::CH_A;
            sdlp_pkg::PH_DA:   w_expect = sdlp_pkg::CH_T;
            sdlp_pkg::PH_DAT:  w_expect = sdlp_pkg::CH_A;
            sdlp_pkg::PH_DATA: w_expect = sdlp_pkg::CH_COLON;
            default:           w_expect = sdlp_pkg::CH_D;
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_step  = '{count: 2'd0, res0: w_marker, res1: w_b};
        if (i_mode == sdlp_pkg::MODE_FLUSH) begin
            if (i_state.event_nonempty) begin
                o_step.count           = 2'd1;
                o_state.event_nonempty = 1'b0;
            end
            o_state.phase   = sdlp_pkg::PH_START;
            o_state.cr_held = 1'b0;
        end else begin
            unique case (i_state.phase)
                sdlp_pkg::PH_START: begin
                    if (i_byte == sdlp_pkg::CH_LF) begin
                        if (i_state.event_nonempty) begin
                            o_step.count           = 2'd1;
                            o_state.event_nonempty = 1'b0;
                        end
                        o_state.cr_held = 1'b0;
                    end else if (i_state.cr_held) begin
                        o_state.cr_held = 1'b0;
                        o_state.phase   = sdlp_pkg::PH_IGNORE;
                    end else if (i_byte == sdlp_pkg::CH_CR) begin
                        o_state.cr_held = 1'b1;
                    end else if (i_byte == sdlp_pkg::CH_D) begin
                        o_state.phase = sdlp_pkg::PH_D;
                    end else begin
                        o_state.phase = sdlp_pkg::PH_IGNORE;
                    end
                end
                sdlp_pkg::PH_D, sdlp_pkg::PH_DA, sdlp_pkg::PH_DAT, sdlp_pkg::PH_DATA: begin
                    o_state.cr_held = 1'b0;
                    if (i_byte == sdlp_pkg::CH_LF) begin
                        o_state.phase = sdlp_pkg::PH_START;
                    end else if (i_byte == w_expect) begin
                        unique case (i_state.phase)
                            sdlp_pkg::PH_D:   o_state.phase = sdlp_pkg::PH_DA;
                            sdlp_pkg::PH_DA:  o_state.phase = sdlp_pkg::PH_DAT;
                            sdlp_pkg::PH_DAT: o_state.phase = sdlp_pkg::PH_DATA;
                            default: begin
                                // separate data lines with a newline once the event holds bytes
                                if (i_state.event_nonempty) begin
                                    o_step.count = 2'd1;
                                    o_step.res0  = w_nl;
                                end
                                o_state.phase = sdlp_pkg::PH_VSTART;
                            end
                        endcase
                    end else begin
                        o_state.phase = sdlp_pkg::PH_IGNORE;
                    end
                end
                sdlp_pkg::PH_VSTART: begin
                    o_state.cr_held = 1'b0;
                    if (i_byte == sdlp_pkg::CH_LF) begin
                        o_state.phase = sdlp_pkg::PH_START;
                    end else if (i_byte == sdlp_pkg::CH_CR) begin
                        o_state.cr_held = 1'b1;
                        o_state.phase   = sdlp_pkg::PH_VALUE;
                    end else if (i_byte == sdlp_pkg::CH_SPACE) begin
                        o_state.phase = sdlp_pkg::PH_VALUE;
                    end else begin
                        o_step.count           = 2'd1;
                        o_step.res0            = w_b;
                        o_state.event_nonempty = 1'b1;
                        o_state.phase          = sdlp_pkg::PH_VALUE;
                    end
                end
                sdlp_pkg::PH_VALUE: begin
                    if (i_byte == sdlp_pkg::CH_LF) begin
                        o_state.cr_held = 1'b0;
                        o_state.phase   = sdlp_pkg::PH_START;
                    end else begin
                        // release a held CR ahead of the new byte
                        if (i_state.cr_held) begin
                            o_step.count           = 2'd1;
                            o_step.res0            = w_cr;
                            o_step.res0.last       = 1'b1;
                            o_state.event_nonempty = 1'b1;
                        end
                        if (i_byte == sdlp_pkg::CH_CR) begin
                            o_state.cr_held = 1'b1;
                        end else begin
                            o_state.cr_held        = 1'b0;
                            o_state.event_nonempty = 1'b1;
                            if (i_state.cr_held) begin
                                o_step.count     = 2'd2;
                                o_step.res0.last = 1'b0;
                            end else begin
                                o_step.count = 2'd1;
                                o_step.res0  = w_b;
                            end
                        end
                    end
                end
                default: begin
                    o_state.cr_held = 1'b0;
                    if (i_byte == sdlp_pkg::CH_LF) begin
                        o_state.phase = sdlp_pkg::PH_START;
                    end else begin
                        o_state.phase = sdlp_pkg::PH_IGNORE;
                    end
                end
            endcase
        end
    end

endmodule

/* sv/sse_data_line_parser.sv */
// Top level of the SSE data line parser: parse state, result queue and handshakes.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-----------------------------------
//  i_in     | in  | valid/ready  | mode, in_byte
//  o_out    | out | valid/ready  | out_kind, out_byte, last_of_run
//
// One item is taken per cycle while the input is ready; its results land in a
// two-entry result queue at the same edge and leave one per cycle while the
// output is ready. The input is ready when the queue is empty or its last
// entry leaves in this cycle. Reset (synchronous, active low) returns the
// parser to line start with an empty event and an empty queue.
module sse_data_line_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdlp_in_if.sink       i_in,
    sdlp_out_if.source    o_out
);

    sdlp_pkg::t_parse_state r_state;
    sdlp_pkg::t_parse_state n_state;
    sdlp_pkg::t_step        w_step;
    sdlp_pkg::t_result      r_q0;
    sdlp_pkg::t_result      r_q1;
    logic [1:0]             r_cnt;
    logic                   w_accept;
    logic                   w_pop;

    sdlp_core u_core (
        .i_mode  (i_in.mode),
        .i_byte  (i_in.in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_step  (w_step)
    );

    assign w_pop    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.out_kind    = r_q0.kind;
    assign o_out.out_byte    = r_q0.data;
    assign o_out.last_of_run = r_q0.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: sdlp_pkg::PH_START, cr_held: 1'b0, event_nonempty: 1'b0};
            r_cnt   <= 2'd0;
        end else if (w_accept) begin
            // queue is drained by now: load the new results
            r_state <= n_state;
            r_cnt   <= w_step.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q0 <= w_step.res0;
            r_q1 <= w_step.res1;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule
